[hdl/rpp_pkg.sv]
// ============================================================================
// rpp_pkg
// Shared types, constants and helper functions for the reply prefix payload
// parser: controller states, result kinds, link states and the command and
// status bundles between controller and datapath.
// ============================================================================
package rpp_pkg;

    // Default depth of the payload buffer.
    localparam int RPP_BUFFER_DEPTH = 64;

    // Fixed reply prefix and the carriage return that ends a payload.
    localparam int          PREFIX_LEN = 13;
    localparam logic [7:0]  CR_BYTE    = 8'h0D;

    // Configuration register indexes.
    localparam logic [1:0] CFG_STATUS_LEAD = 2'd0;
    localparam logic [1:0] CFG_OPENED_CODE = 2'd1;
    localparam logic [1:0] CFG_CLOSED_CODE = 2'd2;

    // Kind of a result item.
    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_LINK    = 2'd2
    } kind_t;

    // Link state as reported on every result.
    typedef enum logic [1:0] {
        LINK_BOOTING = 2'd0,
        LINK_OPENED  = 2'd1,
        LINK_CLOSED  = 2'd2
    } link_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_SEARCH,
        ST_STATUS,
        ST_COLLECT,
        ST_READ,
        ST_PUSH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  pos_inc;
        logic  pos_clr;
        logic  len_clr;
        logic  store_wr;
        logic  rd_clr;
        logic  rd_adv;
        logic  set_open;
        logic  set_closed;
        logic  out_load;
        kind_t out_kind;
        logic  out_last;
    } rpp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pfx_match;
        logic pfx_end;
        logic lead_match;
        logic open_match;
        logic close_match;
        logic is_cr;
        logic len_full;
        logic len_zero;
        logic rd_last;
        logic out_free;
    } rpp_stat_t;

    // Expected byte at a given prefix position.
    function automatic logic [7:0] prefix_byte(input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = "H";
            4'd1:    b = "T";
            4'd2:    b = "T";
            4'd3:    b = "P";
            4'd4:    b = "/";
            4'd5:    b = "1";
            4'd6:    b = ".";
            4'd7:    b = "1";
            4'd8:    b = " ";
            4'd9:    b = "2";
            4'd10:   b = "0";
            4'd11:   b = "7";
            4'd12:   b = " ";
            default: b = "H";
        endcase
        return b;
    endfunction

endpackage

[hdl/reply_prefix_payload_parser.sv]
// ============================================================================
// reply_prefix_payload_parser
// Scans a received byte stream for the reply prefix, tracks link status
// codes and reads out the payload that follows the prefix.
// ============================================================================
// Usage:
//   Input channel: rx_byte with in_valid/in_stall; a transfer happens on a
//   clock edge with in_valid high and in_stall low.
//   Output channel: kind, data_byte, link_state, last with out_valid and
//   out_stall; one result per transfer, last marks the end of a run.
//   Configuration: cfg_we, cfg_index, cfg_data write the status lead byte
//   (0), opened code (1) and closed code (2); write only while idle.
// Timing:
//   Bytes are taken one per cycle unless readout runs or a stalled output
//   holds off the status or collecting state. A byte's status or empty-message
//   result shows in the next cycle. A carriage return ending a payload starts
//   a readout of buffer read, output register load per byte, input held off.
// Reset:
//   Clears the search position, the payload length, the link state
//   (booting), the configuration registers and the output valid flag.
// Stalls:
//   A stalled output holds its result; input is then held off in the
//   status and collecting states and during readout, not while searching.
// ============================================================================
module reply_prefix_payload_parser
    import rpp_pkg::*;
#(
    parameter int BUFFER_DEPTH = RPP_BUFFER_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] kind,
    output logic [7:0] data_byte,
    output logic [1:0] link_state,
    output logic       last
);

    rpp_cmd_t  cmd;
    rpp_stat_t stat;

    // Sequencing of search, status, collection and readout.
    rpp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Registers, payload buffer and output register.
    rpp_datapath #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .rx_byte    (rx_byte),
        .out_stall  (out_stall),
        .cmd        (cmd),
        .stat       (stat),
        .out_valid  (out_valid),
        .kind       (kind),
        .data_byte  (data_byte),
        .link_state (link_state),
        .last       (last)
    );

endmodule

[hdl/rpp_ctrl.sv]
// ============================================================================
// rpp_ctrl
// Controller of the reply prefix payload parser. It walks the prefix search,
// the status step, payload collection and the buffer readout, and issues
// commands to the datapath.
// ============================================================================
module rpp_ctrl
    import rpp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  rpp_stat_t stat,
    output rpp_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    logic   in_fire;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SEARCH;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Input is held off during readout, and while a result waits that could
    // not make room for another one. Searching never produces a result.
    always_comb
    begin
        case (state_reg)
            ST_SEARCH:  in_stall = 1'b0;
            ST_STATUS:  in_stall = !stat.out_free;
            ST_COLLECT: in_stall = !stat.out_free;
            default:    in_stall = 1'b1;
        endcase
    end

    assign in_fire = in_valid && !in_stall;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.out_kind = KIND_PAYLOAD;
        case (state_reg)
            ST_SEARCH:
            begin
                if (in_fire)
                begin
                    if (stat.pfx_match)
                    begin
                        if (stat.pfx_end)
                        begin
                            cmd.pos_clr = 1'b1;
                            cmd.len_clr = 1'b1;
                            state_next  = ST_COLLECT;
                        end
                        else
                        begin
                            cmd.pos_inc = 1'b1;
                        end
                    end
                    else
                    begin
                        cmd.pos_clr = 1'b1;
                        if (stat.lead_match)
                        begin
                            state_next = ST_STATUS;
                        end
                    end
                end
            end
            ST_STATUS:
            begin
                if (in_fire)
                begin
                    if (stat.open_match)
                    begin
                        cmd.set_open = 1'b1;
                        cmd.out_load = 1'b1;
                        cmd.out_kind = KIND_LINK;
                        cmd.out_last = 1'b1;
                    end
                    else if (stat.close_match)
                    begin
                        cmd.set_closed = 1'b1;
                        cmd.out_load   = 1'b1;
                        cmd.out_kind   = KIND_LINK;
                        cmd.out_last   = 1'b1;
                    end
                    cmd.pos_clr = 1'b1;
                    cmd.len_clr = 1'b1;
                    state_next  = ST_SEARCH;
                end
            end
            ST_COLLECT:
            begin
                if (in_fire)
                begin
                    if (stat.len_full)
                    begin
                        cmd.pos_clr = 1'b1;
                        cmd.len_clr = 1'b1;
                        state_next  = ST_SEARCH;
                    end
                    else if (!stat.is_cr)
                    begin
                        cmd.store_wr = 1'b1;
                    end
                    else if (stat.len_zero)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_kind = KIND_EMPTY;
                        cmd.out_last = 1'b1;
                        cmd.pos_clr  = 1'b1;
                        cmd.len_clr  = 1'b1;
                        state_next   = ST_SEARCH;
                    end
                    else
                    begin
                        cmd.rd_clr = 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                // The buffer read data is registered; wait in this state for it.
                state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = KIND_PAYLOAD;
                    cmd.out_last = stat.rd_last;
                    if (stat.rd_last)
                    begin
                        cmd.pos_clr = 1'b1;
                        cmd.len_clr = 1'b1;
                        state_next  = ST_SEARCH;
                    end
                    else
                    begin
                        cmd.rd_adv = 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_SEARCH;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    // A buffer read always hands over to a push on the next cycle.
    a_read_then_push: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |=> (state_reg == ST_PUSH))
        else $error("readout read not followed by push");

    // Payload results are only produced from the readout push state.
    a_payload_from_push: assert property (
        @(posedge clk) disable iff (!rst_n)
        (cmd.out_load && cmd.out_kind == KIND_PAYLOAD) |-> (state_reg == ST_PUSH))
        else $error("payload result outside readout");
`endif

endmodule

[hdl/rpp_datapath.sv]
// ============================================================================
// rpp_datapath
// Datapath of the reply prefix payload parser: configuration registers,
// prefix position, payload buffer memory with its length and read index,
// link state and the output register.
// ============================================================================
module rpp_datapath
    import rpp_pkg::*;
#(
    parameter int BUFFER_DEPTH = RPP_BUFFER_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic [7:0]  rx_byte,
    input  logic        out_stall,
    input  rpp_cmd_t    cmd,
    output rpp_stat_t   stat,
    output logic        out_valid,
    output logic [1:0]  kind,
    output logic [7:0]  data_byte,
    output logic [1:0]  link_state,
    output logic        last
);

    localparam int LEN_W  = $clog2(BUFFER_DEPTH + 1);
    localparam int ADDR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    logic [7:0]       lead_reg;
    logic [7:0]       opened_reg;
    logic [7:0]       closed_reg;
    logic [3:0]       pos_reg;
    logic [3:0]       pos_next;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic [LEN_W-1:0] rd_idx_reg;
    logic [LEN_W-1:0] rd_idx_next;
    link_t            link_reg;
    link_t            link_next;
    logic [7:0]       rd_data_reg;
    logic [7:0]       mem [BUFFER_DEPTH];
    logic             out_valid_reg;
    kind_t            kind_reg;
    logic [7:0]       data_reg;
    link_t            link_out_reg;
    logic             last_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg   <= 8'h00;
            opened_reg <= 8'h00;
            closed_reg <= 8'h00;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_STATUS_LEAD: lead_reg   <= cfg_data;
                CFG_OPENED_CODE: opened_reg <= cfg_data;
                CFG_CLOSED_CODE: closed_reg <= cfg_data;
                default:         lead_reg   <= lead_reg;
            endcase
        end
    end

    // Byte compares and counter status for the controller.
    always_comb
    begin
        stat.pfx_match   = (rx_byte == prefix_byte(pos_reg));
        stat.pfx_end     = (pos_reg == 4'(PREFIX_LEN - 1));
        stat.lead_match  = (rx_byte == lead_reg);
        stat.open_match  = (rx_byte == opened_reg);
        stat.close_match = (rx_byte == closed_reg);
        stat.is_cr       = (rx_byte == CR_BYTE);
        stat.len_full    = (len_reg == LEN_W'(BUFFER_DEPTH));
        stat.len_zero    = (len_reg == '0);
        stat.rd_last     = ((rd_idx_reg + LEN_W'(1)) == len_reg);
        stat.out_free    = !out_valid_reg || !out_stall;
    end

    // Next values of the counters and the link state.
    always_comb
    begin
        pos_next = pos_reg;
        if (cmd.pos_clr)
        begin
            pos_next = 4'd0;
        end
        else if (cmd.pos_inc)
        begin
            pos_next = pos_reg + 4'd1;
        end

        len_next = len_reg;
        if (cmd.len_clr)
        begin
            len_next = '0;
        end
        else if (cmd.store_wr)
        begin
            len_next = len_reg + LEN_W'(1);
        end

        rd_idx_next = rd_idx_reg;
        if (cmd.rd_clr)
        begin
            rd_idx_next = '0;
        end
        else if (cmd.rd_adv)
        begin
            rd_idx_next = rd_idx_reg + LEN_W'(1);
        end

        link_next = link_reg;
        if (cmd.set_open)
        begin
            link_next = LINK_OPENED;
        end
        else if (cmd.set_closed)
        begin
            link_next = LINK_CLOSED;
        end
    end

    // Control counters and link state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= 4'd0;
            len_reg    <= '0;
            rd_idx_reg <= '0;
            link_reg   <= LINK_BOOTING;
        end
        else
        begin
            pos_reg    <= pos_next;
            len_reg    <= len_next;
            rd_idx_reg <= rd_idx_next;
            link_reg   <= link_next;
        end
    end

    // Payload buffer: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.store_wr)
        begin
            mem[len_reg[ADDR_W-1:0]] <= rx_byte;
        end
        rd_data_reg <= mem[rd_idx_reg[ADDR_W-1:0]];
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload; the link state shown is the value after this item.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            kind_reg     <= cmd.out_kind;
            data_reg     <= (cmd.out_kind == KIND_PAYLOAD) ? rd_data_reg : 8'h00;
            link_out_reg <= link_next;
            last_reg     <= cmd.out_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign data_byte  = data_reg;
    assign link_state = link_out_reg;
    assign last       = last_reg;

`ifndef NO_ASSERTIONS
    // The payload length never runs past the buffer depth.
    a_len_bound: assert property (
        @(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(BUFFER_DEPTH))
        else $error("payload length beyond buffer depth");

    // A result is only loaded when the output register has room.
    a_load_room: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> stat.out_free)
        else $error("output register overwritten");

    // The buffer is never written when full.
    a_no_write_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.store_wr |-> !stat.len_full)
        else $error("write into full buffer");

    // Readout never advances past the stored length.
    a_rd_in_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.rd_adv |-> !stat.rd_last)
        else $error("readout past payload end");
`endif

endmodule

[tb/reply_prefix_payload_parser_tb.sv]
// ============================================================================
// reply_prefix_payload_parser_tb
// Self-checking testbench for the reply prefix payload parser. A directed
// table covers status codes, register extremes and an empty message. Random
// traffic follows: well-formed replies, overflowing payloads, status steps,
// broken prefixes and noise. Random gaps and stalls are applied on both
// channels. Every result transfer is compared with an in-bench predictor.
// ============================================================================
module reply_prefix_payload_parser_tb
    import rpp_pkg::*;
();

    localparam int          RANDOM_BYTES = 400;
    localparam int          PHASE_BYTES  = 70;
    localparam int unsigned CYCLE_LIMIT  = 2000000;
    localparam int          DRAIN_LIMIT  = 50000;
    localparam int          REPORT_MAX   = 10;
    localparam logic [8*PREFIX_LEN-1:0] PREFIX_TEXT = "HTTP/1.1 207 ";

    // One expected or observed result.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        link_t      link;
        logic       last;
    } reply_t;

    // One row of the directed table: a byte to send or a register setting.
    typedef struct {
        logic       is_settings;
        logic [7:0] value;
        logic [7:0] lead;
        logic [7:0] opened;
        logic [7:0] closed;
        logic       typed;
        reply_t     want;
    } directed_row_t;

    // Parser modes tracked by the predictor.
    typedef enum logic [1:0] {
        MODE_SCAN,
        MODE_STATUS,
        MODE_COLLECT
    } parse_mode_t;

    // DUT inputs, all known from time zero.
    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [1:0] cfg_index = CFG_STATUS_LEAD;
    logic [7:0] cfg_data  = 8'h00;
    logic       in_valid  = 1'b0;
    logic [7:0] rx_byte   = 8'h00;
    logic       out_stall = 1'b0;

    // DUT outputs.
    logic       in_stall;
    logic       out_valid;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [1:0] link_state;
    logic       last;

    // Side information that travels with the byte on the input channel.
    logic       row_typed = 1'b0;
    reply_t     row_want  = '0;

    // Predictor copy of the registers and the parser state.
    logic [7:0]  lead_copy   = 8'h00;
    logic [7:0]  opened_copy = 8'h00;
    logic [7:0]  closed_copy = 8'h00;
    parse_mode_t mode_copy   = MODE_SCAN;
    int          match_count = 0;
    int          fill_count  = 0;
    logic [7:0]  payload_copy [RPP_BUFFER_DEPTH];
    link_t       link_copy   = LINK_BOOTING;

    reply_t        expected_replies [$];
    directed_row_t directed_rows [$];

    // Statistics and failure bookkeeping.
    int unsigned cycle_count      = 0;
    int          bytes_sent       = 0;
    int          replies_seen     = 0;
    int          runs_seen        = 0;
    int          links_seen       = 0;
    int          settings_written = 0;
    int          mismatch_count   = 0;

    // Traffic shaping state.
    int unsigned nogap_left = 0;
    int unsigned stall_run  = 0;
    logic        stall_on   = 1'b0;

    reply_prefix_payload_parser u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .data_byte  (data_byte),
        .link_state (link_state),
        .last       (last)
    );

    always #10 clk = ~clk;

    // Expected character at one position of the reply prefix.
    function automatic logic [7:0] prefix_char(input int idx);
        return PREFIX_TEXT[8*(PREFIX_LEN-1-idx) +: 8];
    endfunction

    function automatic void queue_reply(input kind_t k, input logic [7:0] d, input logic l);
        reply_t r;
        r.kind = k;
        r.data = d;
        r.link = link_copy;
        r.last = l;
        expected_replies.push_back(r);
    endfunction

    function automatic void restart_scan();
        mode_copy   = MODE_SCAN;
        match_count = 0;
        fill_count  = 0;
    endfunction

    // Advance the parser copy by one byte and queue the results it causes.
    // A typed table row replaces the computed results with its own.
    function automatic void predict_replies(input logic [7:0] b, input logic typed,
                                            input reply_t want);
        int base;
        base = expected_replies.size();
        case (mode_copy)
            MODE_SCAN:
            begin
                if (b == prefix_char(match_count)) begin
                    if (match_count == PREFIX_LEN - 1) begin
                        mode_copy   = MODE_COLLECT;
                        match_count = 0;
                        fill_count  = 0;
                    end
                    else begin
                        match_count++;
                    end
                end
                else begin
                    // A mismatching byte is not tried again at the first position.
                    match_count = 0;
                    if (b == lead_copy)
                        mode_copy = MODE_STATUS;
                end
            end
            MODE_STATUS:
            begin
                // The opened code wins when both codes are equal.
                if (b == opened_copy) begin
                    link_copy = LINK_OPENED;
                    queue_reply(KIND_LINK, 8'h00, 1'b1);
                end
                else if (b == closed_copy) begin
                    link_copy = LINK_CLOSED;
                    queue_reply(KIND_LINK, 8'h00, 1'b1);
                end
                restart_scan();
            end
            default:
            begin
                if (fill_count >= RPP_BUFFER_DEPTH) begin
                    // A full store drops the message, even on a carriage return.
                    restart_scan();
                end
                else if (b != CR_BYTE) begin
                    payload_copy[fill_count] = b;
                    fill_count++;
                end
                else begin
                    if (fill_count == 0)
                        queue_reply(KIND_EMPTY, 8'h00, 1'b1);
                    for (int i = 0; i < fill_count; i++)
                        queue_reply(KIND_PAYLOAD, payload_copy[i], i == fill_count - 1);
                    restart_scan();
                end
            end
        endcase
        if (typed) begin
            while (expected_replies.size() > base)
                void'(expected_replies.pop_back());
            expected_replies.push_back(want);
        end
    endfunction

    function automatic void report_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("%s", msg);
    endfunction

    // Compare one result transfer with the oldest expectation.
    function automatic void check_reply();
        reply_t exp;
        replies_seen++;
        if (kind == KIND_LINK)
            links_seen++;
        if (kind == KIND_PAYLOAD && last)
            runs_seen++;
        if (expected_replies.size() == 0) begin
            report_failure($sformatf("unexpected result: kind %0d data %02h link %0d last %0d",
                                     kind, data_byte, link_state, last));
        end
        else begin
            exp = expected_replies.pop_front();
            if (kind !== exp.kind || data_byte !== exp.data ||
                link_state !== exp.link || last !== exp.last)
                report_failure($sformatf({"result %0d mismatch: kind %0d/%0d data %02h/%02h",
                                          " link %0d/%0d last %0d/%0d (exp/act)"},
                    replies_seen, exp.kind, kind, exp.data, data_byte,
                    exp.link, link_state, exp.last, last));
        end
    endfunction

    // Track register writes, accepted bytes and result transfers.
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_we) begin
                if (cfg_index == CFG_STATUS_LEAD)
                    lead_copy = cfg_data;
                else if (cfg_index == CFG_OPENED_CODE)
                    opened_copy = cfg_data;
                else if (cfg_index == CFG_CLOSED_CODE)
                    closed_copy = cfg_data;
            end
            if (in_valid && !in_stall)
                predict_replies(rx_byte, row_typed, row_want);
            if (out_valid && !out_stall)
                check_reply();
        end
    end

    // Output stalls alternate between free runs and stall runs of random length.
    always @(posedge clk) begin
        if (stall_run == 0) begin
            stall_on = !stall_on;
            if (stall_on)
                stall_run = ($urandom_range(99) < 85) ? $urandom_range(1, 3)
                                                      : $urandom_range(10, 30);
            else
                stall_run = ($urandom_range(99) < 70) ? $urandom_range(1, 6)
                                                      : $urandom_range(20, 80);
        end
        stall_run = stall_run - 1;
        out_stall <= stall_on;
    end

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_replies.size());
            $display("reply_prefix_payload_parser verification failed");
            $finish;
        end
    end

    // Gap after a transfer: mostly none, some short, a few long, and
    // occasional stretches with no gap at all.
    function automatic int unsigned sender_gap();
        int unsigned roll;
        if (nogap_left != 0) begin
            nogap_left--;
            return 0;
        end
        roll = $urandom_range(99);
        if (roll < 5)
            nogap_left = $urandom_range(20, 100);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic typed, input reply_t want);
        int unsigned gap;
        in_valid  <= 1'b1;
        rx_byte   <= b;
        row_typed <= typed;
        row_want  <= want;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        bytes_sent++;
        gap = sender_gap();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_plain(input logic [7:0] b);
        send_byte(b, 1'b0, '0);
    endtask

    task automatic send_prefix();
        for (int i = 0; i < PREFIX_LEN; i++)
            send_plain(prefix_char(i));
    endtask

    // Hold the sender until every expected result has arrived, then let
    // the last byte without a result work its way through.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_settings(input logic [7:0] lead, input logic [7:0] opened,
                                  input logic [7:0] closed);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_STATUS_LEAD;
        cfg_data  <= lead;
        @(posedge clk);
        cfg_index <= CFG_OPENED_CODE;
        cfg_data  <= opened;
        @(posedge clk);
        cfg_index <= CFG_CLOSED_CODE;
        cfg_data  <= closed;
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_written++;
    endtask

    // Builders for the directed table.
    function automatic void add_byte(input logic [7:0] b);
        directed_row_t row;
        row = '{default: '0};
        row.value = b;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_checked(input logic [7:0] b, input kind_t k, input link_t l);
        directed_row_t row;
        row = '{default: '0};
        row.value     = b;
        row.typed     = 1'b1;
        row.want.kind = k;
        row.want.data = 8'h00;
        row.want.link = l;
        row.want.last = 1'b1;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_settings(input logic [7:0] lead, input logic [7:0] opened,
                                         input logic [7:0] closed);
        directed_row_t row;
        row = '{default: '0};
        row.is_settings = 1'b1;
        row.lead        = lead;
        row.opened      = opened;
        row.closed      = closed;
        directed_rows.push_back(row);
    endfunction

    // Payload byte of any value but the carriage return.
    function automatic logic [7:0] payload_value();
        logic [7:0] v;
        v = 8'($urandom_range(0, 255));
        if (v == CR_BYTE)
            v = 8'h0A;
        return v;
    endfunction

    // One random sequence: mostly well-formed traffic with random content.
    task automatic send_sequence();
        int unsigned roll;
        int          count;
        roll = $urandom_range(99);
        if (roll < 45) begin
            // Complete reply, mostly short payloads.
            roll = $urandom_range(99);
            count = (roll < 70) ? $urandom_range(0, 8) :
                    (roll < 92) ? $urandom_range(9, 30) : $urandom_range(60, RPP_BUFFER_DEPTH);
            send_prefix();
            repeat (count) send_plain(payload_value());
            send_plain(CR_BYTE);
        end
        else if (roll < 52) begin
            // Payload that fills the store; the next byte drops the message.
            send_prefix();
            repeat (RPP_BUFFER_DEPTH) send_plain(payload_value());
            send_plain(($urandom_range(1) != 0) ? CR_BYTE : payload_value());
        end
        else if (roll < 72) begin
            // Status step with the opened code, the closed code or another byte.
            send_plain(lead_copy);
            roll = $urandom_range(99);
            send_plain((roll < 40) ? opened_copy : (roll < 80) ? closed_copy
                                                               : 8'($urandom_range(0, 255)));
        end
        else if (roll < 87) begin
            // Prefix broken after a random number of characters.
            count = $urandom_range(1, PREFIX_LEN - 1);
            for (int i = 0; i < count; i++)
                send_plain(prefix_char(i));
            roll = $urandom_range(2);
            send_plain((roll == 0) ? prefix_char(0) : (roll == 1) ? lead_copy
                                                                  : 8'($urandom_range(0, 255)));
        end
        else begin
            // Noise, line feeds and carriage returns among it.
            repeat ($urandom_range(1, 6)) begin
                roll = $urandom_range(9);
                send_plain((roll == 0) ? CR_BYTE : (roll == 1) ? 8'h0A
                                                               : 8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Register settings used between random phases, extremes among them.
    task automatic next_settings(input int phase);
        case (phase % 5)
            0:       write_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                    8'($urandom_range(0, 255)));
            1:       write_settings(8'hFF, 8'h00, 8'hFF);
            2:
            begin
                logic [7:0] code;
                code = 8'($urandom_range(0, 255));
                write_settings(8'($urandom_range(0, 255)), code, code);
            end
            3:       write_settings(prefix_char($urandom_range(0, PREFIX_LEN - 1)),
                                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            default: write_settings(8'h00, 8'hFF, 8'h00);
        endcase
    endtask

    // Main sequence.
    initial begin
        int directed_count;
        int phase;
        int waited;

        // Directed table: reset registers first, then extremes and equal codes.
        add_byte(8'h00);
        add_checked(8'h00, KIND_LINK, LINK_OPENED);
        add_byte(8'hFF);
        add_byte(8'h00);
        add_byte(8'hFF);
        add_settings(8'hFF, 8'h01, 8'hFE);
        add_byte(8'hFF);
        add_checked(8'hFE, KIND_LINK, LINK_CLOSED);
        for (int i = 0; i < PREFIX_LEN; i++)
            add_byte(prefix_char(i));
        add_checked(CR_BYTE, KIND_EMPTY, LINK_CLOSED);
        add_settings(8'hFF, 8'h80, 8'h80);
        add_byte(8'hFF);
        add_checked(8'h80, KIND_LINK, LINK_OPENED);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_settings)
                write_settings(directed_rows[i].lead, directed_rows[i].opened,
                               directed_rows[i].closed);
            else
                send_byte(directed_rows[i].value, directed_rows[i].typed, directed_rows[i].want);
        end
        directed_count = bytes_sent;

        // Random phases, each under its own register setting.
        phase = 0;
        while (bytes_sent < directed_count + RANDOM_BYTES) begin
            if (bytes_sent >= directed_count + phase * PHASE_BYTES) begin
                next_settings(phase);
                phase++;
            end
            send_sequence();
        end

        // Drain the remaining results, then allow a full readout more.
        in_valid <= 1'b0;
        waited = 0;
        while (expected_replies.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (2 * RPP_BUFFER_DEPTH + 16) @(posedge clk);
        if (expected_replies.size() != 0)
            report_failure($sformatf("%0d expected results never arrived",
                                     expected_replies.size()));

        $display("Sent %0d bytes under %0d register settings in %0d cycles.",
                 bytes_sent, settings_written, cycle_count);
        $display("Checked %0d results: %0d payload runs, %0d link updates, %0d failures.",
                 replies_seen, runs_seen, links_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("reply_prefix_payload_parser verification clean");
        else
            $display("reply_prefix_payload_parser verification failed");
        $finish;
    end

endmodule

[reply_prefix_payload_parser.f]
hdl/rpp_pkg.sv
hdl/rpp_ctrl.sv
hdl/rpp_datapath.sv
hdl/reply_prefix_payload_parser.sv
tb/reply_prefix_payload_parser_tb.sv
